>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SRG_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SRG_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Types, codes and prescaler constants of the step rate generator.
// ----------------------------------------------------------------------------
package srg_pkg;

   localparam longint unsigned CLOCK_HZ       = 16000000;
   localparam int              NUM_PRESCALERS = 5;
   localparam int              NUM_PS_MAX     = 5;
   localparam longint unsigned US_PER_S       = 1000000;

   // field widths
   localparam int RATE_W   = 17;
   localparam int SPM_W    = 12;
   localparam int PW_W     = 8;
   localparam int TICKS_W  = 16;
   localparam int DIR_W    = 2;
   localparam int CODE_W   = 3;
   localparam int CMP_W    = 8;
   localparam int REASON_W = 2;

   // divider datapath
   localparam int QUO_W = 30;     // 1e9 fits in 30 bits
   localparam int DIV_W = 29;     // rate times steps per mm fits in 29 bits
   localparam logic [QUO_W-1:0]  DIVIDEND = QUO_W'(1000000000);
   localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(100000);
   localparam int MAX_COUNT = 255;

   // opcodes
   localparam logic OP_SET_RATE = 1'b0;
   localparam logic OP_COMPARE  = 1'b1;

   // stop reasons
   localparam logic [REASON_W-1:0] STOP_NONE    = 2'd0;
   localparam logic [REASON_W-1:0] STOP_ENDSTOP = 2'd1;
   localparam logic [REASON_W-1:0] STOP_EMSTOP  = 2'd2;

   localparam logic [DIR_W-1:0]  DIR_NONE  = 2'd0;
   localparam logic [CODE_W-1:0] CODE_STOP = 3'd0;

   // register indexes
   localparam logic [1:0] REG_STEP_SCALE   = 2'd0;
   localparam logic [1:0] REG_PULSE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_ENDSTOP_TICK = 2'd2;
   localparam logic [1:0] REG_BACK_AWAY    = 2'd3;
   localparam int         CSR_ADDR_W       = 4;

   // prescalers, fastest first
   localparam longint unsigned PS_DIV [NUM_PS_MAX] = '{32, 64, 128, 256, 1024};
   localparam logic [CODE_W-1:0] PS_CODE [NUM_PS_MAX] =
      '{3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
   localparam longint unsigned PS_INC [NUM_PS_MAX] = '{
      US_PER_S / (CLOCK_HZ / PS_DIV[0]),
      US_PER_S / (CLOCK_HZ / PS_DIV[1]),
      US_PER_S / (CLOCK_HZ / PS_DIV[2]),
      US_PER_S / (CLOCK_HZ / PS_DIV[3]),
      US_PER_S / (CLOCK_HZ / PS_DIV[4])};
   localparam longint unsigned PS_LIMIT [NUM_PS_MAX] = '{
      PS_INC[0] * MAX_COUNT, PS_INC[1] * MAX_COUNT, PS_INC[2] * MAX_COUNT,
      PS_INC[3] * MAX_COUNT, PS_INC[4] * MAX_COUNT};

endpackage

>>> sv/srg_if.sv
// ----------------------------------------------------------------------------
// srg_req_if / srg_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface srg_req_if import srg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                op;
   logic [RATE_W-1:0]   rate_um_per_s;
   logic                endstop_high;
   logic                stop_pressed;
   logic [DIR_W-1:0]    direction;

   modport source (output valid, op, rate_um_per_s, endstop_high, stop_pressed,
                   direction, input ready);
   modport sink   (input valid, op, rate_um_per_s, endstop_high, stop_pressed,
                   direction, output ready);
endinterface

interface srg_rsp_if import srg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                step_pulse;
   logic                running;
   logic [CODE_W-1:0]   prescaler_code;
   logic [CMP_W-1:0]    compare_value;
   logic [REASON_W-1:0] stop_reason;
   logic                rate_ok;

   modport source (output valid, step_pulse, running, prescaler_code,
                   compare_value, stop_reason, rate_ok, input ready);
   modport sink   (input valid, step_pulse, running, prescaler_code,
                   compare_value, stop_reason, rate_ok, output ready);
endinterface

>>> sv/step_rate_generator_with_endstop_core.sv
// ----------------------------------------------------------------------------
// step_rate_generator_with_endstop_core
// Feed rate to prescaler/compare conversion with endstop debounce and e-stop.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  req     | in  | valid/ready         | op, rate, endstop, e-stop, direction
//  rsp     | out | valid/ready         | pulse, running, code, compare, reason
//  csr     | in  | APB, pready tied 1  | four config registers
//
//  compare event or zero rate: straight to ST_FINISH, which registers the response.
//  set rate: ST_MUL for the 4-bit-digit multiply, ST_DIV for the radix-2 divide
//  of 1e9, ST_SEL for the prescaler select, ST_SCALE for the compare-count
//  divide, ST_FINISH to load the response.
//  One word in flight; a new word is taken while the response still waits.
//  Reset is synchronous; config registers return to their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module step_rate_generator_with_endstop_core import srg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   srg_req_if.sink               req,
   srg_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV, ST_SEL, ST_SCALE, ST_FINISH
   } state_type;

   state_type            state_ff, state_in;

   // config
   logic [SPM_W-1:0]     spm_ff, spm_in;
   logic [PW_W-1:0]      pw_ff, pw_in;
   logic [TICKS_W-1:0]   ticks_ff, ticks_in;
   logic                 allow_ff, allow_in;

   // architectural state
   logic                 run_ff, run_in;
   logic [CODE_W-1:0]    clksel_ff, clksel_in;
   logic [CMP_W-1:0]     cmp_ff, cmp_in;
   logic [REASON_W-1:0]  reason_ff, reason_in;
   logic [TICKS_W-1:0]   es_run_ff, es_run_in;
   logic [DIR_W-1:0]     ldir_ff, ldir_in;

   // datapath
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [SPM_W-1:0]     spm_sh_ff, spm_sh_in;
   logic [DIV_W-1:0]     acc_ff, acc_in;     // product, then divisor
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic                 pulse_ff, pulse_in;
   logic                 ok_ff, ok_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 o_pulse_ff, o_pulse_in;
   logic                 o_run_ff, o_run_in;
   logic [CODE_W-1:0]    o_code_ff, o_code_in;
   logic [CMP_W-1:0]     o_cmp_ff, o_cmp_in;
   logic [REASON_W-1:0]  o_reason_ff, o_reason_in;
   logic                 o_ok_ff, o_ok_in;

   logic                 csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign req.ready  = (state_ff == ST_IDLE);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.step_pulse     = o_pulse_ff;
   assign rsp.running        = o_run_ff;
   assign rsp.prescaler_code = o_code_ff;
   assign rsp.compare_value  = o_cmp_ff;
   assign rsp.stop_reason    = o_reason_ff;
   assign rsp.rate_ok        = o_ok_ff;

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[3:2])
         REG_STEP_SCALE:   csr_prdata = {20'b0, spm_ff};
         REG_PULSE_WIDTH:  csr_prdata = {24'b0, pw_ff};
         REG_ENDSTOP_TICK: csr_prdata = {16'b0, ticks_ff};
         REG_BACK_AWAY:    csr_prdata = {31'b0, allow_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      logic [RATE_W-1:0]  rate_sat;
      logic [20:0]        pp;
      logic [QUO_W-1:0]   trial;
      logic [QUO_W-1:0]   diff;
      logic               ge;
      logic [DIV_W-1:0]   rem_step;
      logic [QUO_W-1:0]   quo_step;
      logic [QUO_W-1:0]   delay;
      logic               found;
      logic [CODE_W-1:0]  fcode;
      logic [DIV_W-1:0]   finc;
      logic [TICKS_W-1:0] es_cnt;
      logic [DIR_W-1:0]   ldir;
      logic               es_stop;

      state_in     = state_ff;
      spm_in       = spm_ff;
      pw_in        = pw_ff;
      ticks_in     = ticks_ff;
      allow_in     = allow_ff;
      run_in       = run_ff;
      clksel_in    = clksel_ff;
      cmp_in       = cmp_ff;
      reason_in    = reason_ff;
      es_run_in    = es_run_ff;
      ldir_in      = ldir_ff;
      rate_in      = rate_ff;
      spm_sh_in    = spm_sh_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      code_in      = code_ff;
      pulse_in     = pulse_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      o_pulse_in   = o_pulse_ff;
      o_run_in     = o_run_ff;
      o_code_in    = o_code_ff;
      o_cmp_in     = o_cmp_ff;
      o_reason_in  = o_reason_ff;
      o_ok_in      = o_ok_ff;

      rate_sat = (req.rate_um_per_s > RATE_MAX) ? RATE_MAX : req.rate_um_per_s;

      // 4-bit digit of the step scale, top digit first
      pp = 21'(rate_ff) * 21'(spm_sh_ff[SPM_W-1 -: 4]);

      // one restoring divide step; the shifted remainder needs all 30 bits
      trial    = {rem_ff, quo_ff[QUO_W-1]};
      diff     = trial - {1'b0, acc_ff};
      ge       = (trial >= {1'b0, acc_ff});
      rem_step = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_step = {quo_ff[QUO_W-2:0], ge};

      delay = quo_ff - QUO_W'(pw_ff);
      found = 1'b0;
      fcode = CODE_STOP;
      finc  = '0;
      for (int i = 0; i < NUM_PS_MAX; i++) begin
         if (!found && i < NUM_PRESCALERS && PS_INC[i] != 0 &&
             {34'b0, delay} <= PS_LIMIT[i]) begin
            found = 1'b1;
            fcode = PS_CODE[i];
            finc  = DIV_W'(PS_INC[i]);
         end
      end

      // endstop debounce
      if (req.endstop_high) begin
         es_cnt = (es_run_ff != '1) ? es_run_ff + TICKS_W'(1) : es_run_ff;
      end else begin
         es_cnt = '0;
      end
      ldir    = (ldir_ff == DIR_NONE) ? req.direction : ldir_ff;
      es_stop = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_FINISH;
               pulse_in = 1'b0;
               ok_in    = 1'b0;
               if (req.op == OP_SET_RATE) begin
                  if (rate_sat == '0) begin
                     run_in    = 1'b0;
                     clksel_in = CODE_STOP;
                     ok_in     = 1'b1;
                  end else begin
                     rate_in   = rate_sat;
                     spm_sh_in = spm_ff;
                     acc_in    = '0;
                     cnt_in    = 5'd2;
                     state_in  = ST_MUL;
                  end
               end else if (run_ff) begin
                  if (es_cnt >= ticks_ff) begin
                     es_run_in = '0;
                     ldir_in   = ldir;
                     if (!allow_ff || req.direction == ldir) begin
                        es_stop   = 1'b1;
                        run_in    = 1'b0;
                        clksel_in = CODE_STOP;
                        reason_in = STOP_ENDSTOP;
                     end
                  end else begin
                     es_run_in = es_cnt;
                     ldir_in   = DIR_NONE;
                  end
                  if (!es_stop) begin
                     if (req.stop_pressed) begin
                        run_in    = 1'b0;
                        clksel_in = CODE_STOP;
                        reason_in = STOP_EMSTOP;
                     end else begin
                        pulse_in = 1'b1;
                     end
                  end
               end
            end
         end
         ST_MUL: begin
            acc_in    = {acc_ff[DIV_W-5:0], 4'b0} + DIV_W'(pp);
            spm_sh_in = {spm_sh_ff[SPM_W-5:0], 4'b0};
            cnt_in    = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               if (acc_in == '0) begin
                  run_in    = 1'b0;
                  clksel_in = CODE_STOP;
                  state_in  = ST_FINISH;
               end else begin
                  rem_in   = '0;
                  quo_in   = DIVIDEND;
                  cnt_in   = 5'(QUO_W - 1);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV, ST_SCALE: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               if (state_ff == ST_DIV) begin
                  state_in = ST_SEL;
               end else begin
                  run_in    = 1'b1;
                  clksel_in = code_ff;
                  cmp_in    = quo_step[CMP_W-1:0];
                  ok_in     = 1'b1;
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_SEL: begin
            // quotient < pulse width, delay below the fastest tick, or no fit
            if (quo_ff < QUO_W'(pw_ff) || {34'b0, delay} < PS_INC[0] || !found) begin
               run_in    = 1'b0;
               clksel_in = CODE_STOP;
               state_in  = ST_FINISH;
            end else begin
               // quotient < 256, so only the low 8 bits need stepping
               code_in  = fcode;
               acc_in   = finc;
               rem_in   = DIV_W'(delay[QUO_W-1:CMP_W]);
               quo_in   = {delay[CMP_W-1:0], {(QUO_W-CMP_W){1'b0}}};
               cnt_in   = 5'(CMP_W - 1);
               state_in = ST_SCALE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               o_pulse_in   = pulse_ff;
               o_run_in     = run_ff;
               o_code_in    = clksel_ff;
               o_cmp_in     = cmp_ff;
               o_reason_in  = reason_ff;
               o_ok_in      = ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_STEP_SCALE:   spm_in   = csr_pwdata[SPM_W-1:0];
            REG_PULSE_WIDTH:  pw_in    = csr_pwdata[PW_W-1:0];
            REG_ENDSTOP_TICK: ticks_in = csr_pwdata[TICKS_W-1:0];
            REG_BACK_AWAY:    allow_in = csr_pwdata[0];
            default:          spm_in   = spm_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spm_ff       <= SPM_W'(400);
         pw_ff        <= PW_W'(2);
         ticks_ff     <= TICKS_W'(4);
         allow_ff     <= 1'b1;
         run_ff       <= 1'b0;
         clksel_ff    <= CODE_STOP;
         cmp_ff       <= '0;
         reason_ff    <= STOP_NONE;
         es_run_ff    <= '0;
         ldir_ff      <= DIR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spm_ff       <= spm_in;
         pw_ff        <= pw_in;
         ticks_ff     <= ticks_in;
         allow_ff     <= allow_in;
         run_ff       <= run_in;
         clksel_ff    <= clksel_in;
         cmp_ff       <= cmp_in;
         reason_ff    <= reason_in;
         es_run_ff    <= es_run_in;
         ldir_ff      <= ldir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rate_ff     <= rate_in;
      spm_sh_ff   <= spm_sh_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      code_ff     <= code_in;
      pulse_ff    <= pulse_in;
      ok_ff       <= ok_in;
      o_pulse_ff  <= o_pulse_in;
      o_run_ff    <= o_run_in;
      o_code_ff   <= o_code_in;
      o_cmp_ff    <= o_cmp_in;
      o_reason_ff <= o_reason_in;
      o_ok_ff     <= o_ok_in;
   end

   `SRG_ASSERT(a_run_has_code, run_ff == (clksel_ff != CODE_STOP), "run and code disagree")
   `SRG_ASSERT(a_div_nonzero, (state_ff == ST_DIV || state_ff == ST_SCALE) |-> (acc_ff != '0), "zero divisor")
   `SRG_ASSERT(a_pulse_running, (rsp_valid_ff && o_pulse_ff) |-> (o_run_ff && !o_ok_ff), "bad pulse word")
   `SRG_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> (state_ff == ST_IDLE && !rsp_valid_ff), "not idle after reset")

endmodule
